@@ src/tdsp_pkg.sv @@
`timescale 1ns / 1ps
package tdsp_pkg;

  localparam int unsigned NODE_W = 10;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned TIME_W = 48;
  localparam int unsigned SUM_W  = TIME_W + 1;
  localparam int unsigned COST_W = 34;
  localparam int unsigned ROOT_W = 17;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  localparam logic CFG_SOURCE = 1'b0;
  localparam logic CFG_GOAL   = 1'b1;

  typedef struct packed {
    logic [NODE_W-1:0] from_node;
    logic [NODE_W-1:0] to_node;
    logic [WORD_W-1:0] edge_a;
    logic [WORD_W-1:0] edge_b;
    logic              last;
  } in_word_t;

  typedef struct packed {
    logic [TIME_W-1:0] arrival_time;
    logic              reachable;
  } out_word_t;

  typedef struct packed {
    logic [TIME_W-1:0] best_time;
    logic              reached;
    logic              finished;
  } node_ent_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_INIT,
    S_SCAN,
    S_FINISH,
    S_EDGE_RD,
    S_EDGE_CHK,
    S_COST,
    S_RELAX,
    S_GOAL_RD,
    S_GOAL,
    S_EMIT
  } ctrl_state_e;

  typedef enum logic [2:0] {
    C_IDLE,
    C_SQRT,
    C_DIV,
    C_ACC,
    C_DONE
  } cost_state_e;

  typedef struct packed {
    logic load;
    logic clear;
    logic init;
    logic ctr_clr;
    logic scan;
    logic finish;
    logic edge_chk;
    logic cost_wait;
    logic relax;
    logic goal_rd;
    logic goal;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic last_acc;
    logic clear_done;
    logic src_ok;
    logic scan_done;
    logic found;
    logic edge_end;
    logic edge_match;
    logic cost_done;
    logic out_free;
  } sts_t;

endpackage

@@ src/tdsp_cost.sv @@
`timescale 1ns / 1ps
module tdsp_cost import tdsp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [TIME_W-1:0] time_i,
  input  logic [WORD_W-1:0] offset_i,
  input  logic [WORD_W-1:0] numer_i,
  output logic              done_o,
  output logic [COST_W-1:0] cost_o
);

  localparam int unsigned ROOT_STEPS = WORD_W / 2;
  localparam int unsigned STEP_W     = $clog2(WORD_W);
  localparam int unsigned REM_W      = SUM_W + 1;
  localparam logic [1:0]  CAND_ZERO  = 2'd0;
  localparam logic [1:0]  CAND_ROOT  = 2'd1;
  localparam logic [1:0]  CAND_UP    = 2'd2;

  cost_state_e st_q, st_d;

  logic [SUM_W-1:0]  base_q, dsr_q;
  logic [WORD_W-1:0] numer_q, rad_q, root_q, bit_q, nsh_q, quo_q;
  logic [REM_W-1:0]  rem_q;
  logic [STEP_W-1:0] step_q;
  logic [1:0]        cand_q;
  logic [ROOT_W-1:0] wait_q;
  logic [COST_W-1:0] best_q;

  logic [WORD_W:0]   root_sum;
  logic              root_take;
  logic [REM_W-1:0]  rem_sh;
  logic              rem_take;
  logic [ROOT_W-1:0] r0, r1;
  logic              ge1, ge2;
  logic [WORD_W:0]   ceil_w;
  logic [COST_W-1:0] cand_cost;
  logic              keep;
  logic              has_next;
  logic [1:0]        nxt;
  logic [SUM_W-1:0]  nxt_dsr;
  logic              sqrt_end, div_end;

  assign root_sum  = {1'b0, root_q} + {1'b0, bit_q};
  assign root_take = {1'b0, rad_q} >= root_sum;
  assign rem_sh    = {rem_q[REM_W-2:0], nsh_q[WORD_W-1]};
  assign rem_take  = rem_sh >= {1'b0, dsr_q};
  assign r0        = ROOT_W'(root_q[ROOT_STEPS-1:0]);
  assign r1        = r0 + ROOT_W'(1);
  assign ge1       = SUM_W'(r0) >= base_q;
  assign ge2       = SUM_W'(r1) >= base_q;
  assign ceil_w    = {1'b0, quo_q} + {{WORD_W{1'b0}}, |rem_q};
  assign cand_cost = COST_W'(wait_q) + COST_W'(ceil_w);
  assign keep      = (cand_q == CAND_ZERO) || (cand_cost < best_q);
  assign nxt_dsr   = (nxt == CAND_ROOT) ? SUM_W'(r0) : SUM_W'(r1);
  assign sqrt_end  = step_q == STEP_W'(ROOT_STEPS - 1);
  assign div_end   = step_q == STEP_W'(WORD_W - 1);

  always_comb begin
    has_next = 1'b0;
    nxt      = cand_q;
    unique case (cand_q)
      CAND_ZERO: begin
        if (ge1) begin
          has_next = 1'b1;
          nxt      = CAND_ROOT;
        end else if (ge2) begin
          has_next = 1'b1;
          nxt      = CAND_UP;
        end
      end
      CAND_ROOT: begin
        if (ge2) begin
          has_next = 1'b1;
          nxt      = CAND_UP;
        end
      end
      default: has_next = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= C_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      C_IDLE:  if (start_i) st_d = C_SQRT;
      C_SQRT:  if (sqrt_end) st_d = C_DIV;
      C_DIV:   if (div_end) st_d = C_ACC;
      C_ACC:   st_d = has_next ? C_DIV : C_DONE;
      C_DONE:  st_d = start_i ? C_SQRT : C_IDLE;
      default: st_d = C_IDLE;
    endcase
  end

  always_comb begin
    done_o = (st_q == C_DONE);
    cost_o = best_q;
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      C_IDLE, C_DONE: begin
        if (start_i) begin
          base_q  <= SUM_W'(time_i) + SUM_W'(offset_i);
          numer_q <= numer_i;
          rad_q   <= numer_i;
          root_q  <= '0;
          bit_q   <= {2'b01, {(WORD_W-2){1'b0}}};
          step_q  <= '0;
        end
      end
      C_SQRT: begin
        if (root_take) begin
          rad_q  <= rad_q - root_sum[WORD_W-1:0];
          root_q <= (root_q >> 1) + bit_q;
        end else begin
          root_q <= root_q >> 1;
        end
        bit_q <= bit_q >> 2;
        if (sqrt_end) begin
          cand_q <= CAND_ZERO;
          dsr_q  <= (base_q == '0) ? SUM_W'(1) : base_q;
          wait_q <= '0;
          rem_q  <= '0;
          quo_q  <= '0;
          nsh_q  <= numer_q;
          step_q <= '0;
        end else begin
          step_q <= step_q + STEP_W'(1);
        end
      end
      C_DIV: begin
        rem_q  <= rem_take ? (rem_sh - {1'b0, dsr_q}) : rem_sh;
        quo_q  <= {quo_q[WORD_W-2:0], rem_take};
        nsh_q  <= nsh_q << 1;
        step_q <= step_q + STEP_W'(1);
      end
      C_ACC: begin
        if (keep) begin
          best_q <= cand_cost;
        end
        if (has_next) begin
          cand_q <= nxt;
          dsr_q  <= (nxt_dsr == '0) ? SUM_W'(1) : nxt_dsr;
          wait_q <= ROOT_W'(nxt_dsr - base_q);
          rem_q  <= '0;
          quo_q  <= '0;
          nsh_q  <= numer_q;
          step_q <= '0;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ src/tdsp_datapath.sv @@
`timescale 1ns / 1ps
module tdsp_datapath import tdsp_pkg::*; #(
  parameter int unsigned NODES = 1024,
  parameter int unsigned EDGES = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_word_t          in_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_word_t         out_word_o,
  input  logic              cfg_we_i,
  input  logic              cfg_index_i,
  input  logic [NODE_W-1:0] cfg_data_i
);

  localparam int unsigned NW  = $clog2(NODES);
  localparam int unsigned CW  = $clog2(NODES + 1);
  localparam int unsigned EW  = (EDGES > 1) ? $clog2(EDGES) : 1;
  localparam int unsigned ECW = $clog2(EDGES + 1);
  localparam node_ent_t INIT_ENT = '{best_time: TIME_MAX, reached: 1'b0, finished: 1'b0};

  logic [NODE_W-1:0] source_q, goal_q;

  logic [2*NODE_W-1:0] ends_mem  [EDGES];
  logic [WORD_W-1:0]   offs_mem  [EDGES];
  logic [WORD_W-1:0]   numer_mem [EDGES];
  logic [2*NODE_W-1:0] e_ends_q;
  logic [WORD_W-1:0]   e_offs_q, e_numer_q;
  logic [ECW-1:0]      ecount_q, ecnt_q;

  node_ent_t         node_mem [NODES];
  node_ent_t         mem_rd_q, mem_wd;
  logic              mem_we;
  logic [NW-1:0]     mem_wa, rd_addr;

  logic [CW-1:0]     ctr_q;
  logic              scan_vld_q;
  logic [NW-1:0]     rd_idx_q;
  logic              found_q;
  logic [NW-1:0]     pick_q, other_q;
  logic [TIME_W-1:0] pick_time_q, arr_q;

  logic              in_acc, store_ok, cand, scan_more;
  logic [NODE_W-1:0] p_end, q_end;
  logic              p_hit, q_hit;
  logic              goal_ok, goal_reach;
  logic              cost_done;
  logic [COST_W-1:0] cost;
  logic [SUM_W-1:0]  arr_sum;
  out_word_t         res_q, out_word_q;
  logic              out_valid_q, out_free;

  assign in_acc     = in_valid_i && cmd_i.load;
  assign in_stall_o = !cmd_i.load;
  assign store_ok   = in_acc && (ecount_q < ECW'(EDGES))
                      && (32'(in_word_i.from_node) < 32'(NODES))
                      && (32'(in_word_i.to_node) < 32'(NODES));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      source_q <= '0;
      goal_q   <= '0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_SOURCE) begin
        source_q <= cfg_data_i;
      end else if (cfg_index_i == CFG_GOAL) begin
        goal_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_ok) begin
      ends_mem[ecount_q[EW-1:0]]  <= {in_word_i.to_node, in_word_i.from_node};
      offs_mem[ecount_q[EW-1:0]]  <= in_word_i.edge_a;
      numer_mem[ecount_q[EW-1:0]] <= in_word_i.edge_b;
    end
    e_ends_q  <= ends_mem[ecnt_q[EW-1:0]];
    e_offs_q  <= offs_mem[ecnt_q[EW-1:0]];
    e_numer_q <= numer_mem[ecnt_q[EW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ecount_q <= '0;
      ecnt_q   <= '0;
    end else begin
      if (cmd_i.emit && out_free) begin
        ecount_q <= '0;
      end else if (store_ok) begin
        ecount_q <= ecount_q + ECW'(1);
      end
      if (cmd_i.finish) begin
        ecnt_q <= '0;
      end else if (cmd_i.edge_chk) begin
        ecnt_q <= ecnt_q + ECW'(1);
      end
    end
  end

  assign p_end = e_ends_q[NODE_W-1:0];
  assign q_end = e_ends_q[2*NODE_W-1:NODE_W];
  assign p_hit = NW'(p_end) == pick_q;
  assign q_hit = NW'(q_end) == pick_q;

  always_comb begin
    if (cmd_i.goal_rd) begin
      rd_addr = NW'(goal_q);
    end else if (cmd_i.cost_wait || cmd_i.relax) begin
      rd_addr = other_q;
    end else begin
      rd_addr = ctr_q[NW-1:0];
    end
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = ctr_q[NW-1:0];
    mem_wd = INIT_ENT;
    priority if (cmd_i.clear) begin
      mem_we = 1'b1;
    end else if (cmd_i.init) begin
      mem_we = 1'b1;
      mem_wa = NW'(source_q);
      mem_wd = '{best_time: '0, reached: 1'b1, finished: 1'b0};
    end else if (cmd_i.finish) begin
      mem_we = 1'b1;
      mem_wa = pick_q;
      mem_wd = '{best_time: pick_time_q, reached: 1'b1, finished: 1'b1};
    end else if (cmd_i.relax) begin
      mem_we = !mem_rd_q.reached || (arr_q < mem_rd_q.best_time);
      mem_wa = other_q;
      mem_wd = '{best_time: arr_q, reached: 1'b1, finished: mem_rd_q.finished};
    end else begin
      mem_we = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      node_mem[mem_wa] <= mem_wd;
    end
    mem_rd_q <= node_mem[rd_addr];
  end

  assign scan_more = ctr_q < CW'(NODES);
  assign cand = scan_vld_q && mem_rd_q.reached && !mem_rd_q.finished
                && (!found_q || (mem_rd_q.best_time < pick_time_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_q      <= '0;
      scan_vld_q <= 1'b0;
      found_q    <= 1'b0;
    end else begin
      scan_vld_q <= cmd_i.scan && scan_more;
      if (cmd_i.ctr_clr) begin
        ctr_q   <= '0;
        found_q <= 1'b0;
      end else begin
        if (cmd_i.clear || (cmd_i.scan && scan_more)) begin
          ctr_q <= ctr_q + CW'(1);
        end
        if (cand) begin
          found_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= ctr_q[NW-1:0];
    if (cand) begin
      pick_q      <= rd_idx_q;
      pick_time_q <= mem_rd_q.best_time;
    end
    if (cmd_i.edge_chk) begin
      other_q <= p_hit ? NW'(q_end) : NW'(p_end);
    end
    if (cmd_i.cost_wait && cost_done) begin
      arr_q <= arr_sum[TIME_W] ? TIME_MAX : arr_sum[TIME_W-1:0];
    end
    if (cmd_i.goal) begin
      res_q.arrival_time <= goal_reach ? mem_rd_q.best_time : '0;
      res_q.reachable    <= goal_reach;
    end
    if (cmd_i.emit && out_free) begin
      out_word_q <= res_q;
    end
  end

  assign arr_sum = SUM_W'(pick_time_q) + SUM_W'(cost);

  tdsp_cost u_cost (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.edge_chk && (p_hit || q_hit)),
    .time_i   (pick_time_q),
    .offset_i (e_offs_q),
    .numer_i  (e_numer_q),
    .done_o   (cost_done),
    .cost_o   (cost)
  );

  assign goal_ok    = 32'(goal_q) < 32'(NODES);
  assign goal_reach = goal_ok && mem_rd_q.reached;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  always_comb begin
    sts_o.last_acc   = in_acc && in_word_i.last;
    sts_o.clear_done = ctr_q == CW'(NODES - 1);
    sts_o.src_ok     = 32'(source_q) < 32'(NODES);
    sts_o.scan_done  = cmd_i.scan && !scan_more && !scan_vld_q;
    sts_o.found      = found_q;
    sts_o.edge_end   = ecnt_q == ecount_q;
    sts_o.edge_match = p_hit || q_hit;
    sts_o.cost_done  = cost_done;
    sts_o.out_free   = out_free;
  end

endmodule

@@ src/tdsp_ctrl.sv @@
`timescale 1ns / 1ps
module tdsp_ctrl import tdsp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:     if (sts_i.last_acc) state_d = S_CLEAR;
      S_CLEAR:    if (sts_i.clear_done) state_d = sts_i.src_ok ? S_INIT : S_GOAL_RD;
      S_INIT:     state_d = S_SCAN;
      S_SCAN:     if (sts_i.scan_done) state_d = sts_i.found ? S_FINISH : S_GOAL_RD;
      S_FINISH:   state_d = S_EDGE_RD;
      S_EDGE_RD:  state_d = sts_i.edge_end ? S_SCAN : S_EDGE_CHK;
      S_EDGE_CHK: state_d = sts_i.edge_match ? S_COST : S_EDGE_RD;
      S_COST:     if (sts_i.cost_done) state_d = S_RELAX;
      S_RELAX:    state_d = S_EDGE_RD;
      S_GOAL_RD:  state_d = S_GOAL;
      S_GOAL:     state_d = S_EMIT;
      S_EMIT:     if (sts_i.out_free) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.load    = 1'b1;
        cmd_o.ctr_clr = 1'b1;
      end
      S_CLEAR: cmd_o.clear = 1'b1;
      S_INIT: begin
        cmd_o.init    = 1'b1;
        cmd_o.ctr_clr = 1'b1;
      end
      S_SCAN:   cmd_o.scan = 1'b1;
      S_FINISH: cmd_o.finish = 1'b1;
      S_EDGE_RD: begin
        cmd_o.ctr_clr = sts_i.edge_end;
      end
      S_EDGE_CHK: cmd_o.edge_chk = 1'b1;
      S_COST:     cmd_o.cost_wait = 1'b1;
      S_RELAX:    cmd_o.relax = 1'b1;
      S_GOAL_RD:  cmd_o.goal_rd = 1'b1;
      S_GOAL:     cmd_o.goal = 1'b1;
      S_EMIT:     cmd_o.emit = 1'b1;
      default:    cmd_o = '0;
    endcase
  end

endmodule

@@ src/time_dependent_shortest_path_unit.sv @@
// Earliest-arrival search over an undirected graph whose edge crossing time depends on the
// departure time. Edge words are taken one per cycle while the block is idle and stored; the
// word with last set also starts the search, and the block then stalls its input until the
// single result word has been placed in the output register. The search opens with a clearing
// pass over the node memory. Each finished node then costs a minimum scan through the node
// memory's single read port, a step to mark it finished, a read and check of every stored edge,
// and for every edge touching that node a cost from the bit-serial square root and the
// one-bit-per-cycle divider, repeated for each extra wait candidate (at most two). Results are
// the earliest arrival at the goal, held at the 48-bit maximum, or zero with reachable low when
// the goal is not reached.
`timescale 1ns / 1ps
module time_dependent_shortest_path_unit import tdsp_pkg::*; #(
  parameter int unsigned NODES = 1024,
  parameter int unsigned EDGES = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_word_t          in_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_word_t         out_word_o,
  input  logic              cfg_we_i,
  input  logic              cfg_index_i,
  input  logic [NODE_W-1:0] cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  tdsp_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  tdsp_datapath #(
    .NODES (NODES),
    .EDGES (EDGES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  a_last_starts_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_word_i.last) |=> in_stall_o)
    else $error("input not stalled after the last word");

  a_relax_after_cost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.relax |-> $past(sts.cost_done))
    else $error("relaxation without a finished cost");

  a_one_writer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.clear, cmd.init, cmd.finish, cmd.relax}))
    else $error("node memory has more than one writer");

  a_result_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.emit))
    else $error("result word appeared outside emit");

endmodule

@@ bench/time_dependent_shortest_path_unit_test.sv @@
`timescale 1ns / 1ps
module time_dependent_shortest_path_unit_test;
  import tdsp_pkg::*;

  localparam int unsigned NODE_COUNT = 1024;
  localparam int unsigned LINK_COUNT = 4096;
  localparam longint unsigned ARRIVAL_MAX = 64'h0000_FFFF_FFFF_FFFF;

  class arrival_predictor;
    int unsigned link_u[$];
    int unsigned link_v[$];
    longint unsigned link_a[$];
    longint unsigned link_b[$];
    int unsigned src;
    int unsigned dst;
    out_word_t expected_arrivals[$];
    int unsigned mismatches;

    function new();
      src = 0;
      dst = 0;
      mismatches = 0;
    endfunction

    function void set_register(logic index, logic [NODE_W-1:0] value);
      if (index == CFG_SOURCE) begin
        src = value;
      end else begin
        dst = value;
      end
    endfunction

    function longint unsigned floor_root(longint unsigned v);
      longint unsigned root;
      longint unsigned bitpos;
      root = 0;
      bitpos = 64'd1 << 62;
      while (bitpos > v) bitpos = bitpos >> 2;
      while (bitpos != 0) begin
        if (v >= root + bitpos) begin
          v = v - (root + bitpos);
          root = (root >> 1) + bitpos;
        end else begin
          root = root >> 1;
        end
        bitpos = bitpos >> 2;
      end
      return root;
    endfunction

    function longint unsigned waited_cost(longint unsigned base, longint unsigned b,
                                          longint unsigned x);
      longint unsigned d;
      d = base + x;
      if (d == 0) d = 1;
      return x + b / d + ((b % d) != 0 ? 1 : 0);
    endfunction

    function longint unsigned crossing_cost(longint unsigned t, longint unsigned a,
                                            longint unsigned b);
      longint unsigned base;
      longint unsigned r;
      longint unsigned best;
      longint unsigned c;
      base = a + t;
      r = floor_root(b);
      best = waited_cost(base, b, 0);
      if (r >= base) begin
        c = waited_cost(base, b, r - base);
        if (c < best) best = c;
      end
      if (r + 1 >= base) begin
        c = waited_cost(base, b, r + 1 - base);
        if (c < best) best = c;
      end
      return best;
    endfunction

    function out_word_t earliest_arrival();
      longint unsigned best_at[NODE_COUNT];
      bit done_at[NODE_COUNT];
      bit seen_at[NODE_COUNT];
      int unsigned pick;
      int unsigned other;
      bit found;
      longint unsigned arr;
      out_word_t res;
      for (int i = 0; i < NODE_COUNT; i++) begin
        best_at[i] = ARRIVAL_MAX;
        done_at[i] = 0;
        seen_at[i] = 0;
      end
      best_at[src] = 0;
      seen_at[src] = 1;
      forever begin
        found = 0;
        pick = 0;
        for (int i = 0; i < NODE_COUNT; i++) begin
          if (seen_at[i] && !done_at[i] && (!found || best_at[i] < best_at[pick])) begin
            pick = i;
            found = 1;
          end
        end
        if (!found) break;
        done_at[pick] = 1;
        for (int e = 0; e < link_u.size(); e++) begin
          if (link_u[e] == pick) begin
            other = link_v[e];
          end else if (link_v[e] == pick) begin
            other = link_u[e];
          end else begin
            continue;
          end
          arr = best_at[pick] + crossing_cost(best_at[pick], link_a[e], link_b[e]);
          if (arr > ARRIVAL_MAX) arr = ARRIVAL_MAX;
          if (!seen_at[other] || arr < best_at[other]) begin
            best_at[other] = arr;
            seen_at[other] = 1;
          end
        end
      end
      if (seen_at[dst]) begin
        res.arrival_time = best_at[dst][TIME_W-1:0];
        res.reachable = 1'b1;
      end else begin
        res.arrival_time = '0;
        res.reachable = 1'b0;
      end
      return res;
    endfunction

    function void note_edge(in_word_t w);
      if (link_u.size() < LINK_COUNT) begin
        link_u.insert(link_u.size(), w.from_node);
        link_v.insert(link_v.size(), w.to_node);
        link_a.insert(link_a.size(), w.edge_a);
        link_b.insert(link_b.size(), w.edge_b);
      end
      if (w.last) begin
        expected_arrivals.insert(expected_arrivals.size(), earliest_arrival());
        link_u.delete();
        link_v.delete();
        link_a.delete();
        link_b.delete();
      end
    endfunction

    function void check_arrival(out_word_t got);
      out_word_t want;
      if (expected_arrivals.size() == 0) begin
        $error("unexpected result word: arrival_time %0d reachable %0b",
               got.arrival_time, got.reachable);
        mismatches++;
        return;
      end
      want = expected_arrivals.pop_front();
      if (got.arrival_time !== want.arrival_time) begin
        $error("arrival_time: expected %0d, actual %0d", want.arrival_time, got.arrival_time);
        mismatches++;
      end
      if (got.reachable !== want.reachable) begin
        $error("reachable: expected %0b, actual %0b", want.reachable, got.reachable);
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_word_t in_word_i;
  logic out_valid_o;
  logic out_stall_i;
  out_word_t out_word_o;
  logic cfg_we_i;
  logic cfg_index_i;
  logic [NODE_W-1:0] cfg_data_i;

  arrival_predictor sb;
  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned sent;
  int unsigned cur_src;
  int unsigned cur_dst;

  time_dependent_shortest_path_unit uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_word_i(in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o(out_word_o),
    .cfg_we_i(cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #200ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_arrival(out_word_o);
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_word(in_word_t w);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i <= w;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_edge(w);
    sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.expected_arrivals.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_register(logic index, logic [NODE_W-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_register(index, value);
  endtask

  task automatic set_ends(int unsigned s, int unsigned g);
    write_register(CFG_SOURCE, s[NODE_W-1:0]);
    write_register(CFG_GOAL, g[NODE_W-1:0]);
    cur_src = s;
    cur_dst = g;
    @(posedge clk_i);
  endtask

  function automatic in_word_t make_word(int unsigned u, int unsigned v, longint unsigned a,
                                         longint unsigned b, bit lst);
    in_word_t w;
    w.from_node = u[NODE_W-1:0];
    w.to_node = v[NODE_W-1:0];
    w.edge_a = a[WORD_W-1:0];
    w.edge_b = b[WORD_W-1:0];
    w.last = lst;
    return w;
  endfunction

  function automatic logic [WORD_W-1:0] pick_value(bit allow_zero);
    case ($urandom_range(9))
      0: return allow_zero ? 32'd0 : 32'd1;
      1: return 32'd1;
      2: return 32'hFFFF_FFFF;
      3, 4: return $urandom_range(1, 50);
      5, 6: return $urandom_range(1, 1000000);
      default: return $urandom;
    endcase
  endfunction

  task automatic random_graph();
    int unsigned pool[5];
    int unsigned n;
    int unsigned u;
    int unsigned v;
    pool[0] = cur_src;
    pool[1] = cur_dst;
    pool[2] = $urandom_range(NODE_COUNT - 1);
    pool[3] = $urandom_range(NODE_COUNT - 1);
    pool[4] = $urandom_range(NODE_COUNT - 1);
    n = $urandom_range(1, 7);
    for (int k = 0; k < n; k++) begin
      u = ($urandom_range(9) == 0) ? $urandom_range(NODE_COUNT - 1) : pool[$urandom_range(4)];
      v = ($urandom_range(9) == 0) ? $urandom_range(NODE_COUNT - 1) : pool[$urandom_range(4)];
      send_word(make_word(u, v, pick_value($urandom_range(19) == 0), pick_value(0),
                          k == n - 1));
    end
  endtask

  initial begin
    sb = new();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_word_i = '0;
    out_stall_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = CFG_SOURCE;
    cfg_data_i = '0;
    idle_pct = 0;
    stall_pct = 0;
    sent = 0;
    cur_src = 0;
    cur_dst = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Source equals goal, then the widest nodes and values.
    send_word(make_word(0, 5, 3, 10, 1'b1));
    drain();
    set_ends(0, 1023);
    send_word(make_word(1023, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
    drain();
    send_word(make_word(0, 1023, 1, 32'hFFFF_FFFF, 1'b1));
    drain();
    // Unreachable goal, self loops and repeated edges.
    set_ends(1023, 0);
    send_word(make_word(1023, 1023, 5, 7, 1'b0));
    send_word(make_word(1023, 512, 5, 7, 1'b0));
    send_word(make_word(1023, 512, 2, 9, 1'b0));
    send_word(make_word(341, 682, 1, 1, 1'b1));
    drain();
    // A zero offset from the source at time zero gives a zero divisor.
    set_ends(682, 341);
    send_word(make_word(682, 5, 0, 100, 1'b0));
    send_word(make_word(5, 341, 0, 1, 1'b0));
    send_word(make_word(341, 682, 0, 32'hFFFF_FFFF, 1'b1));
    drain();
    // Waiting pays off: small offset with a large numerator.
    set_ends(1, 2);
    send_word(make_word(1, 3, 1, 1000000, 1'b0));
    send_word(make_word(3, 2, 7, 40000, 1'b0));
    send_word(make_word(1, 2, 1, 32'h8000_0000, 1'b1));
    drain();

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        1: begin idle_pct = 51; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 51; end
        3: begin idle_pct = 28; stall_pct = 28; end
        default: begin idle_pct = 0; stall_pct = 0; end
      endcase
      while (sent < 25 + 95 * (phase + 1)) begin
        case ($urandom_range(5))
          0: set_ends(0, $urandom_range(NODE_COUNT - 1));
          1: set_ends(NODE_COUNT - 1, $urandom_range(NODE_COUNT - 1));
          2: set_ends($urandom_range(NODE_COUNT - 1), $urandom_range(NODE_COUNT - 1));
          default: ;
        endcase
        random_graph();
        drain();
      end
    end

    repeat (50) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.expected_arrivals.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

@@ sim.f @@
src/tdsp_pkg.sv
src/tdsp_cost.sv
src/tdsp_datapath.sv
src/tdsp_ctrl.sv
src/time_dependent_shortest_path_unit.sv
bench/time_dependent_shortest_path_unit_test.sv
